### rtl/sample_channel_mixer_macros.svh
// Assertion macros used by the mixer controller.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef SAMPLE_CHANNEL_MIXER_MACROS_SVH
`define SAMPLE_CHANNEL_MIXER_MACROS_SVH

// Implication in the same cycle.
`define SCM_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mixer assertion failed");

// Implication in the next cycle.
`define SCM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mixer assertion failed");

`endif

### rtl/scm_pkg.sv
package scm_pkg;

    localparam int DEF_SAMPLE_SLOTS        = 64;
    localparam int DEF_NUM_CHANNELS        = 16;
    localparam int DEF_SAMPLE_MEMORY_BYTES = 65536;

    localparam logic [6:0] SAMPLES_IN_USE_RST  = 7'd64;
    localparam logic [4:0] CHANNELS_IN_USE_RST = 5'd16;

    // Register index as decoded from paddr[2].
    localparam logic REG_SAMPLES_IN_USE  = 1'b0;
    localparam logic REG_CHANNELS_IN_USE = 1'b1;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BAD_ID = 2'd1;
    localparam logic [1:0] ST_BAD_CH = 2'd2;

    localparam logic [16:0] MAX_LENGTH = 17'h10000;

    typedef enum logic [3:0] {
        OP_WRITE  = 4'd0,
        OP_DEFINE = 4'd1,
        OP_UNLOAD = 4'd2,
        OP_PLAY   = 4'd3,
        OP_LOOP   = 4'd4,
        OP_CLEAR  = 4'd5,
        OP_CLRALL = 4'd6,
        OP_QUERY  = 4'd7,
        OP_TICK   = 4'd8
    } op_t;

    typedef struct packed {
        logic [3:0]  operation;
        logic [15:0] address;
        logic [7:0]  data_byte;
        logic [16:0] sample_length;
        logic [5:0]  sample_id;
        logic [3:0]  channel_number;
        logic        override;
    } cmd_t;

    typedef struct packed {
        logic [1:0] status;
        logic       complete;
        logic [7:0] mixed_sample;
        logic       sample_out_valid;
    } result_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_TBL,
        S_ASSIGN,
        S_TICK,
        S_TDRAIN,
        S_RESP
    } state_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic tbl_read;
        logic assign_ch;
        logic tick_step;
        logic tick_drain;
    } dp_cmd_t;

    typedef struct packed {
        logic tick_end;
    } dp_sts_t;

endpackage

### rtl/sample_channel_mixer.sv
// Multichannel 8-bit sample playback mixer. Issue a command by raising start
// while busy is low; the command is taken at that clock edge and busy stays
// high until its result has been shown. Every command gives exactly one
// result item, which is valid on result in the single cycle marked by done.
// The receiver cannot stall: it must capture result whenever done is high.
// Table and channel commands run in an execute state before done (play and
// loop instead read the sample table memory, then assign the channel). A tick
// walks the channels in use one per cycle through the single read port of
// the sample memory, then a drain state adds the last read before done.
// No clearing pass is needed after reset; the sample memory must be written
// before a channel plays from it.
module sample_channel_mixer
#(
    parameter int SAMPLE_SLOTS        = scm_pkg::DEF_SAMPLE_SLOTS,
    parameter int NUM_CHANNELS        = scm_pkg::DEF_NUM_CHANNELS,
    parameter int SAMPLE_MEMORY_BYTES = scm_pkg::DEF_SAMPLE_MEMORY_BYTES
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  scm_pkg::cmd_t     cmd,
    output logic              busy,
    output logic              done,
    output scm_pkg::result_t  result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import scm_pkg::*;

    logic [6:0] samples_in_use_reg;
    logic [4:0] channels_in_use_reg;
    logic       cfg_wr;
    dp_cmd_t    dcmd;
    dp_sts_t    sts;

    // The configuration registers are written at the APB access phase, decoded
    // on paddr[2]. Writes must happen only while idle; this is not enforced.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            samples_in_use_reg  <= SAMPLES_IN_USE_RST;
            channels_in_use_reg <= CHANNELS_IN_USE_RST;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_SAMPLES_IN_USE)
            begin
                samples_in_use_reg <= pwdata[6:0];
            end
            else
            begin
                channels_in_use_reg <= pwdata[4:0];
            end
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_CHANNELS_IN_USE)
        begin
            prdata[4:0] = channels_in_use_reg;
        end
        else
        begin
            prdata[6:0] = samples_in_use_reg;
        end
    end

    // The controller sequences each command; the datapath holds the sample
    // memory, the sample table and all channel state.
    scm_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (cmd.operation),
        .sts       (sts),
        .dcmd      (dcmd),
        .busy      (busy),
        .done      (done)
    );

    scm_dp
    #(
        .SAMPLE_SLOTS        (SAMPLE_SLOTS),
        .NUM_CHANNELS        (NUM_CHANNELS),
        .SAMPLE_MEMORY_BYTES (SAMPLE_MEMORY_BYTES)
    )
    u_dp
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .samples_in_use  (samples_in_use_reg),
        .channels_in_use (channels_in_use_reg),
        .dcmd            (dcmd),
        .sts             (sts),
        .result          (result)
    );

endmodule

### rtl/scm_ctrl.sv
module scm_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [3:0]        operation,
    input  scm_pkg::dp_sts_t  sts,
    output scm_pkg::dp_cmd_t  dcmd,
    output logic              busy,
    output logic              done
);
    import scm_pkg::*;
    `include "sample_channel_mixer_macros.svh"

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (op_t'(operation))
                        OP_PLAY, OP_LOOP: state_next = S_TBL;
                        OP_TICK:          state_next = S_TICK;
                        default:          state_next = S_EXEC;
                    endcase
                end
            end
            S_EXEC:   state_next = S_RESP;
            S_TBL:    state_next = S_ASSIGN;
            S_ASSIGN: state_next = S_RESP;
            S_TICK:
            begin
                if (sts.tick_end)
                begin
                    state_next = S_TDRAIN;
                end
            end
            S_TDRAIN: state_next = S_RESP;
            S_RESP:   state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        dcmd            = '0;
        dcmd.load       = (state_reg == S_IDLE) && start;
        dcmd.exec       = (state_reg == S_EXEC);
        dcmd.tbl_read   = (state_reg == S_TBL);
        dcmd.assign_ch  = (state_reg == S_ASSIGN);
        dcmd.tick_step  = (state_reg == S_TICK);
        dcmd.tick_drain = (state_reg == S_TDRAIN);
        busy            = (state_reg != S_IDLE);
        done            = (state_reg == S_RESP);
    end

    `SCM_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    `SCM_ASSERT_NEXT(a_done_single, done, !done && !busy)
    `SCM_ASSERT_SAME(a_done_busy, done, busy)
    `SCM_ASSERT_NEXT(a_tick_drain, (state_reg == S_TICK) && sts.tick_end,
                     state_reg == S_TDRAIN)

endmodule

### rtl/scm_dp.sv
module scm_dp
#(
    parameter int SAMPLE_SLOTS        = scm_pkg::DEF_SAMPLE_SLOTS,
    parameter int NUM_CHANNELS        = scm_pkg::DEF_NUM_CHANNELS,
    parameter int SAMPLE_MEMORY_BYTES = scm_pkg::DEF_SAMPLE_MEMORY_BYTES
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  scm_pkg::cmd_t     cmd,
    input  logic [6:0]        samples_in_use,
    input  logic [4:0]        channels_in_use,
    input  scm_pkg::dp_cmd_t  dcmd,
    output scm_pkg::dp_sts_t  sts,
    output scm_pkg::result_t  result
);
    import scm_pkg::*;

    localparam int SID_W = (SAMPLE_SLOTS > 1) ? $clog2(SAMPLE_SLOTS) : 1;
    localparam int CH_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int CTR_W = $clog2(NUM_CHANNELS + 1);
    localparam int MA_W  = $clog2(SAMPLE_MEMORY_BYTES);

    // Sample memory and sample table memories.
    logic [7:0]  smem [SAMPLE_MEMORY_BYTES];
    logic [15:0] tbl_start_mem [SAMPLE_SLOTS];
    logic [16:0] tbl_size_mem [SAMPLE_SLOTS];
    logic [SAMPLE_SLOTS-1:0] tbl_vld_reg;

    logic [7:0]  mem_rd_reg;
    logic [15:0] tbl_start_rd_reg;
    logic [16:0] tbl_size_rd_reg;
    logic        tbl_vld_rd_reg;

    // Channel state.
    logic [15:0] ch_start_reg [NUM_CHANNELS];
    logic [16:0] ch_size_reg  [NUM_CHANNELS];
    logic [15:0] ch_pos_reg   [NUM_CHANNELS];
    logic [16:0] ch_rem_reg   [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] ch_has_reg;
    logic [NUM_CHANNELS-1:0] ch_loop_reg;

    cmd_t             cmd_reg;
    result_t          res_reg;
    logic [CTR_W-1:0] ctr_reg;
    logic [7:0]       sum_reg;
    logic             pend_reg;

    logic [31:0]      id_lim;
    logic [31:0]      ch_lim;
    logic             id_bad;
    logic             ch_bad;
    logic [SID_W-1:0] tbl_idx;
    logic [CH_W-1:0]  ch_idx;
    logic [16:0]      len_sat;
    logic             sel_active;
    logic [15:0]      pos_eff;
    logic [16:0]      rem_eff;
    logic [16:0]      addr_sum;
    logic [15:0]      rd_addr;
    logic             rd_in_range;
    logic             tick_do;
    logic [7:0]       sum_next;
    logic [15:0]      a_start;
    logic [16:0]      a_size;
    logic             a_force;
    logic             a_apply;
    logic [1:0]       a_status;
    result_t          exec_res;
    op_t              op;

    assign op      = op_t'(cmd_reg.operation);
    assign id_lim  = (32'(samples_in_use) < SAMPLE_SLOTS) ? 32'(samples_in_use)
                                                          : 32'(SAMPLE_SLOTS);
    assign ch_lim  = (32'(channels_in_use) < NUM_CHANNELS) ? 32'(channels_in_use)
                                                           : 32'(NUM_CHANNELS);
    assign id_bad  = 32'(cmd_reg.sample_id) >= id_lim;
    assign ch_bad  = 32'(cmd_reg.channel_number) >= ch_lim;
    assign tbl_idx = SID_W'(32'(cmd_reg.sample_id));
    assign ch_idx  = dcmd.tick_step ? ctr_reg[CH_W-1:0]
                                    : CH_W'(32'(cmd_reg.channel_number));
    assign len_sat = (cmd_reg.sample_length > MAX_LENGTH) ? MAX_LENGTH
                                                          : cmd_reg.sample_length;

    assign sel_active = ch_has_reg[ch_idx] &&
                        ((ch_rem_reg[ch_idx] != 17'd0) || ch_loop_reg[ch_idx]);
    assign pos_eff    = (ch_rem_reg[ch_idx] == 17'd0) ? 16'd0 : ch_pos_reg[ch_idx];
    assign rem_eff    = (ch_rem_reg[ch_idx] == 17'd0) ? ch_size_reg[ch_idx]
                                                      : ch_rem_reg[ch_idx];
    assign addr_sum    = {1'b0, ch_start_reg[ch_idx]} + {1'b0, pos_eff};
    assign rd_addr     = addr_sum[15:0];
    assign rd_in_range = 32'(rd_addr) < SAMPLE_MEMORY_BYTES;

    assign sts.tick_end = 32'(ctr_reg) >= ch_lim;
    assign tick_do      = dcmd.tick_step && !sts.tick_end && sel_active;
    assign sum_next     = sum_reg + (pend_reg ? mem_rd_reg : 8'd0);

    assign a_start  = tbl_vld_rd_reg ? tbl_start_rd_reg : 16'd0;
    assign a_size   = tbl_vld_rd_reg ? tbl_size_rd_reg : 17'd0;
    assign a_force  = (op == OP_LOOP) || cmd_reg.override;
    assign a_status = id_bad ? ST_BAD_ID : (ch_bad ? ST_BAD_CH : ST_OK);
    assign a_apply  = !id_bad && !ch_bad && (a_force || !sel_active);

    // Result of the single-step commands.
    always_comb
    begin
        exec_res = '0;
        unique case (op)
            OP_DEFINE, OP_UNLOAD:
            begin
                exec_res.status = id_bad ? ST_BAD_ID : ST_OK;
            end
            OP_CLEAR:
            begin
                if (ch_bad)
                begin
                    exec_res.status = ST_BAD_CH;
                end
            end
            OP_QUERY:
            begin
                if (ch_bad)
                begin
                    exec_res.status   = ST_BAD_CH;
                    exec_res.complete = 1'b1;
                end
                else if (ch_loop_reg[ch_idx])
                begin
                    exec_res.complete = 1'b0;
                end
                else
                begin
                    exec_res.complete = !ch_has_reg[ch_idx] ||
                                        (ch_rem_reg[ch_idx] == 17'd0);
                end
            end
            default:
            begin
            end
        endcase
    end

    // Sample memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (dcmd.exec && (op == OP_WRITE) && (32'(cmd_reg.address) < SAMPLE_MEMORY_BYTES))
        begin
            smem[MA_W'(32'(cmd_reg.address))] <= cmd_reg.data_byte;
        end
        mem_rd_reg <= smem[MA_W'(32'(rd_addr))];
    end

    // Sample table memories.
    always_ff @(posedge clk)
    begin
        if (dcmd.exec && !id_bad && ((op == OP_DEFINE) || (op == OP_UNLOAD)))
        begin
            tbl_start_mem[tbl_idx] <= (op == OP_DEFINE) ? cmd_reg.address : 16'd0;
            tbl_size_mem[tbl_idx]  <= (op == OP_DEFINE) ? len_sat : 17'd0;
        end
        tbl_start_rd_reg <= tbl_start_mem[tbl_idx];
        tbl_size_rd_reg  <= tbl_size_mem[tbl_idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tbl_vld_reg    <= '0;
            tbl_vld_rd_reg <= 1'b0;
        end
        else
        begin
            if (dcmd.exec && !id_bad && ((op == OP_DEFINE) || (op == OP_UNLOAD)))
            begin
                tbl_vld_reg[tbl_idx] <= 1'b1;
            end
            if (dcmd.tbl_read)
            begin
                tbl_vld_rd_reg <= tbl_vld_reg[tbl_idx];
            end
        end
    end

    // Channel state, command register and result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                ch_start_reg[i] <= '0;
                ch_size_reg[i]  <= '0;
                ch_pos_reg[i]   <= '0;
                ch_rem_reg[i]   <= '0;
            end
            ch_has_reg  <= '0;
            ch_loop_reg <= '0;
            cmd_reg     <= '0;
            res_reg     <= '0;
            ctr_reg     <= '0;
            sum_reg     <= '0;
            pend_reg    <= 1'b0;
        end
        else
        begin
            if (dcmd.load)
            begin
                cmd_reg  <= cmd;
                ctr_reg  <= '0;
                sum_reg  <= '0;
                pend_reg <= 1'b0;
            end

            if (dcmd.exec)
            begin
                res_reg <= exec_res;
                unique case (op)
                    OP_CLEAR:
                    begin
                        if (!ch_bad)
                        begin
                            ch_start_reg[ch_idx] <= '0;
                            ch_size_reg[ch_idx]  <= '0;
                            ch_pos_reg[ch_idx]   <= '0;
                            ch_rem_reg[ch_idx]   <= '0;
                            ch_has_reg[ch_idx]   <= 1'b0;
                            ch_loop_reg[ch_idx]  <= 1'b0;
                        end
                    end
                    OP_CLRALL:
                    begin
                        for (int i = 0; i < NUM_CHANNELS; i++)
                        begin
                            ch_start_reg[i] <= '0;
                            ch_size_reg[i]  <= '0;
                            ch_pos_reg[i]   <= '0;
                            ch_rem_reg[i]   <= '0;
                        end
                        ch_has_reg  <= '0;
                        ch_loop_reg <= '0;
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (dcmd.assign_ch)
            begin
                res_reg <= '{status: a_status, default: '0};
                if (a_apply)
                begin
                    ch_start_reg[ch_idx] <= a_start;
                    ch_size_reg[ch_idx]  <= a_size;
                    ch_pos_reg[ch_idx]   <= '0;
                    ch_rem_reg[ch_idx]   <= a_size;
                    ch_has_reg[ch_idx]   <= (a_size != 17'd0);
                    ch_loop_reg[ch_idx]  <= (op == OP_LOOP);
                end
            end

            if (dcmd.tick_step)
            begin
                sum_reg  <= sum_next;
                pend_reg <= tick_do && rd_in_range;
                if (!sts.tick_end)
                begin
                    ctr_reg <= ctr_reg + 1'b1;
                end
                if (tick_do)
                begin
                    ch_pos_reg[ch_idx] <= pos_eff + 16'd1;
                    ch_rem_reg[ch_idx] <= rem_eff - 17'd1;
                end
            end

            if (dcmd.tick_drain)
            begin
                sum_reg  <= sum_next;
                pend_reg <= 1'b0;
                res_reg  <= '{status: ST_OK, complete: 1'b0, mixed_sample: sum_next,
                              sample_out_valid: 1'b1};
            end
        end
    end

    assign result = res_reg;

endmodule
